/* rtl/core/lch_hist_pkg.sv */
// Shared types, constants and binning helper for the LCH color histogram.
package lch_hist_pkg;

    // Default width of the bin counters and the pixel total.
    localparam int COUNT_WIDTH_DEF = 22;

    // Fraction bits of the incoming fixed point channels.
    localparam int FRAC_BITS = 4;

    // Pixel channel width and stream packing.
    localparam int PIX_W       = 15;
    localparam int S_TDATA_W   = 48;

    // Result field widths and stream packing.
    localparam int NUM_BINS    = 38;
    localparam int BIN_IDX_W   = 6;
    localparam int OUT_CNT_W   = 22;
    localparam int PCT_W       = 15;
    localparam int M_TDATA_W   = 48;

    // Percentage scale: 100 percent in Q.8 form.
    localparam int PCT_SCALE   = 25600;

    // Bin groups: width in channel units, bin count and index of the top bin.
    localparam int L_BIN_W     = 10;
    localparam int L_BIN_N     = 10;
    localparam int L_BASE      = 0;
    localparam int C_BIN_W     = 10;
    localparam int C_BIN_N     = 10;
    localparam int C_BASE      = 10;
    localparam int H_BIN_W     = 20;
    localparam int H_BIN_N     = 18;
    localparam int H_BASE      = 20;
    localparam int MAX_GROUP_N = 18;

    // Channel select codes for the update sequencer.
    localparam logic [1:0] CH_LIGHT  = 2'd0;
    localparam logic [1:0] CH_CHROMA = 2'd1;
    localparam logic [1:0] CH_HUE    = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUMP_RD,
        S_BUMP_WR,
        S_EM_RD,
        S_EM_LD,
        S_EM_DIV,
        S_EM_OUT
    } t_state;

    // Output bin index of a non-negative channel value. The bin number is the
    // count of thresholds the value reaches, so the top bin stays open.
    function automatic logic [BIN_IDX_W-1:0] bin_index_of(
        input logic signed [PIX_W-1:0] v,
        input int                      bin_w,
        input int                      bin_n,
        input int                      base
    );
        int q;
        q = 0;
        for (int k = 1; k < MAX_GROUP_N; k++) begin
            if ((k < bin_n) && (int'(v) >= k * bin_w * (1 << FRAC_BITS))) begin
                q = q + 1;
            end
        end
        return BIN_IDX_W'(base + bin_n - 1 - q);
    endfunction

endpackage

/* rtl/core/lch_hist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lch_hist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lch_color_histogram_unit.sv */
// Top level of the LCH color histogram: binning, counter memory and report.
//
// Each accepted pixel (L, C, H as signed fixed point) is fully binned before
// the next beat is taken: the bin counters sit in one RAM with one write and
// one read port, and the three channel bins are updated one after another by
// a read and a write each, through one saturating incrementer. A beat with
// tlast set is binned and counted first, then the block reports all 38 bins,
// top lightness bin first. Each bin is read, loaded, divided by the shared
// bit-serial divider into a 15-bit floor(25600 * count / pixels) and then
// loaded into the output register once that register is free. The
// histogram and pixel total are clear again as the last bin is loaded into the
// output register; no clearing pass is needed. Negative channel values fall
// into no bin, but the pixel is still counted. All counters saturate.
module lch_color_histogram_unit
    import lch_hist_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // lightness [14:0], chroma [29:15], hue [44:30], zero pad [47:45]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tlast,
    output logic                 s_axis_tready,
    // bin_index [5:0], bin_count [27:6], bin_percent [42:28], zero pad [47:43]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tvalid,
    output logic                 m_axis_tlast,
    input  logic                 m_axis_tready
);

    localparam int DIV_W = COUNT_WIDTH + PCT_W;
    localparam int STEP_W = $clog2(PCT_W);
    localparam logic [BIN_IDX_W-1:0] LAST_BIN = BIN_IDX_W'(NUM_BINS - 1);

    t_state r_state, n_state;

    // Pixel registers.
    logic signed [PIX_W-1:0] r_lig, r_chr, r_hue;
    logic                    r_last;
    logic [1:0]              r_chan;

    // Histogram state.
    logic [NUM_BINS-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_total;

    // Report sequencing and divider.
    logic [BIN_IDX_W-1:0]   r_bin;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [DIV_W-1:0]       r_rem;
    logic [DIV_W-1:0]       r_dsh;
    logic [PCT_W-1:0]       r_quo;
    logic [STEP_W-1:0]      r_step;

    // Output register.
    logic                 r_out_valid;
    logic [BIN_IDX_W-1:0] r_out_idx;
    logic [OUT_CNT_W-1:0] r_out_cnt;
    logic [PCT_W-1:0]     r_out_pct;
    logic                 r_out_last;

    // Combinational control.
    logic                    accept;
    logic                    out_free;
    logic signed [PIX_W-1:0] chan_val;
    logic [BIN_IDX_W-1:0]    chan_bin;
    logic                    chan_neg;
    logic [COUNT_WIDTH-1:0]  bump_cur;
    logic [COUNT_WIDTH-1:0]  em_cnt;
    logic                    ram_we;
    logic [BIN_IDX_W-1:0]    ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    logic                    div_ge;
    logic [COUNT_WIDTH+OUT_CNT_W-1:0] cnt_ext;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // Channel under update and its bin.
    always_comb begin
        case (r_chan)
            CH_LIGHT: begin
                chan_val = r_lig;
                chan_bin = bin_index_of(r_lig, L_BIN_W, L_BIN_N, L_BASE);
            end
            CH_CHROMA: begin
                chan_val = r_chr;
                chan_bin = bin_index_of(r_chr, C_BIN_W, C_BIN_N, C_BASE);
            end
            default: begin
                chan_val = r_hue;
                chan_bin = bin_index_of(r_hue, H_BIN_W, H_BIN_N, H_BASE);
            end
        endcase
        chan_neg = chan_val[PIX_W-1];
    end

    // Counter entries never written since the last clear read as zero.
    assign bump_cur = r_valid[chan_bin] ? ram_rdata : '0;
    assign em_cnt   = r_valid[r_bin] ? ram_rdata : '0;
    assign div_ge   = (r_rem >= r_dsh);

    // Counter memory.
    lch_hist_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (chan_bin),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BUMP_RD;
                end
            end
            S_BUMP_RD: n_state = S_BUMP_WR;
            S_BUMP_WR: begin
                if (r_chan != CH_HUE) begin
                    n_state = S_BUMP_RD;
                end else if (r_last) begin
                    n_state = S_EM_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EM_RD: n_state = S_EM_LD;
            S_EM_LD: n_state = S_EM_DIV;
            S_EM_DIV: begin
                if (r_step == '0) begin
                    n_state = S_EM_OUT;
                end
            end
            S_EM_OUT: begin
                if (out_free) begin
                    n_state = (r_bin == LAST_BIN) ? S_IDLE : S_EM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_raddr     = chan_bin;
        ram_wdata     = (bump_cur != '1) ? bump_cur + 1'b1 : bump_cur;
        case (r_state)
            S_IDLE:    s_axis_tready = 1'b1;
            S_BUMP_WR: ram_we = !chan_neg;
            S_EM_RD:   ram_raddr = r_bin;
            default: begin
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pixel capture and channel counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= CH_LIGHT;
        end else if (accept) begin
            r_chan <= CH_LIGHT;
        end else if (r_state == S_BUMP_WR && r_chan != CH_HUE) begin
            r_chan <= r_chan + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lig  <= s_axis_tdata[PIX_W-1:0];
            r_chr  <= s_axis_tdata[2*PIX_W-1:PIX_W];
            r_hue  <= s_axis_tdata[3*PIX_W-1:2*PIX_W];
            r_last <= s_axis_tlast;
        end
    end

    // Valid bits and pixel total; both clear once the last bin is loaded for output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
        end else begin
            if (r_state == S_EM_OUT && out_free && r_bin == LAST_BIN) begin
                r_valid <= '0;
                r_total <= '0;
            end else begin
                if (ram_we) begin
                    r_valid[chan_bin] <= 1'b1;
                end
                if (accept && r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
            end
        end
    end

    // Report bin counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else if (r_state == S_EM_OUT && out_free) begin
            r_bin <= (r_bin == LAST_BIN) ? '0 : r_bin + 1'b1;
        end
    end

    // Bit-serial restoring divider: one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == S_EM_LD) begin
            r_step <= STEP_W'(PCT_W - 1);
        end else if (r_state == S_EM_DIV && r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EM_LD) begin
            r_cnt <= em_cnt;
            r_rem <= DIV_W'(em_cnt) * DIV_W'(PCT_SCALE);
            r_dsh <= DIV_W'(r_total) << (PCT_W - 1);
            r_quo <= '0;
        end else if (r_state == S_EM_DIV) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[PCT_W-2:0], div_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    // Output register; the bin count keeps its low 22 bits.
    assign cnt_ext = {{OUT_CNT_W{1'b0}}, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EM_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EM_OUT && out_free) begin
            r_out_idx  <= r_bin;
            r_out_cnt  <= cnt_ext[OUT_CNT_W-1:0];
            r_out_pct  <= r_quo;
            r_out_last <= (r_bin == LAST_BIN);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(M_TDATA_W - BIN_IDX_W - OUT_CNT_W - PCT_W){1'b0}},
                            r_out_pct, r_out_cnt, r_out_idx};

`ifndef SYNTHESIS
    // The pixel total is never zero while a percentage is being divided.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_DIV) |-> (r_dsh != '0))
        else $error("divider runs with zero pixel total");

    // A finished quotient never exceeds one hundred percent.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_OUT) |-> (r_quo <= PCT_W'(PCT_SCALE)))
        else $error("percentage above full scale");

    // Loading the last bin leaves an empty histogram behind.
    a_clear_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_OUT && out_free && r_bin == LAST_BIN)
        |=> (r_valid == '0 && r_total == '0 && r_state == S_IDLE))
        else $error("histogram not cleared after report");

    // No pixel is taken while a report is in progress.
    a_no_accept_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_DIV || r_state == S_EM_OUT) |-> !s_axis_tready)
        else $error("pixel accepted during report");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the LCH color histogram: directed table, then random images.
`timescale 1ns / 1ps

module tb;
    import lch_hist_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_ITEMS  = 92;
    localparam int CALM_ITEMS  = 25;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 50;
    localparam int NO_BIN      = -1;

    // One pixel beat; typed rows carry the three bins a lone pixel must land in.
    typedef struct {
        logic signed [PIX_W-1:0] l;
        logic signed [PIX_W-1:0] c;
        logic signed [PIX_W-1:0] h;
        bit                      last;
        bit                      typed;
        int                      bl;
        int                      bc;
        int                      bh;
    } t_pixel_row;

    // One reported bin as it should leave the block.
    typedef struct packed {
        logic [BIN_IDX_W-1:0] idx;
        logic [OUT_CNT_W-1:0] cnt;
        logic [PCT_W-1:0]     pct;
        logic                 last;
    } t_bin_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tlast;
    logic                 m_axis_tready = 1'b0;

    // Histogram mirror kept by the testbench.
    logic [COUNT_WIDTH_DEF-1:0] bin_tally [NUM_BINS];
    logic [COUNT_WIDTH_DEF-1:0] pixel_tally;
    t_bin_report                bin_reports_q [$];

    int err_cnt = 0;
    int cycle_cnt = 0;
    bit calm_tail = 1'b0;
    bit long_hold_req = 1'b0;

    lch_color_histogram_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Adds one channel value to its group; negative values land nowhere.
    function automatic void file_channel(input logic signed [PIX_W-1:0] v, input int bin_w,
                                         input int bin_n, input int base);
        int q;
        int idx;
        if (v < 0) return;
        q = int'(v) / (bin_w << FRAC_BITS);
        if (q > bin_n - 1) q = bin_n - 1;
        idx = base + bin_n - 1 - q;
        if (bin_tally[idx] != {COUNT_WIDTH_DEF{1'b1}}) bin_tally[idx]++;
    endfunction

    // Bins one pixel and, on the last pixel of an image, emits the 38 bin reports if publish is set.
    function automatic void tally_pixel(input t_pixel_row px, input bit publish);
        t_bin_report     rep;
        longint unsigned cnt_wide;
        longint unsigned pct;
        file_channel(px.l, L_BIN_W, L_BIN_N, L_BASE);
        file_channel(px.c, C_BIN_W, C_BIN_N, C_BASE);
        file_channel(px.h, H_BIN_W, H_BIN_N, H_BASE);
        if (pixel_tally != {COUNT_WIDTH_DEF{1'b1}}) pixel_tally++;
        if (!px.last) return;
        for (int i = 0; i < NUM_BINS; i++) begin
            cnt_wide = bin_tally[i];
            pct = 0;
            if (pixel_tally != 0) pct = (cnt_wide * PCT_SCALE) / pixel_tally;
            rep.idx  = BIN_IDX_W'(i);
            rep.cnt  = OUT_CNT_W'(cnt_wide);
            rep.pct  = PCT_W'(pct);
            rep.last = (i == NUM_BINS - 1);
            if (publish) bin_reports_q.push_back(rep);
        end
        for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
        pixel_tally = '0;
    endfunction

    // Random channel value: mostly in the binned range, some near bin edges,
    // some negative, some with fully random bits.
    function automatic logic signed [PIX_W-1:0] chan_value(input int bin_w, input int bin_n);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 32767);
            1: v = -int'($urandom_range(1, 16384));
            2, 3: v = $urandom_range(1, bin_n) * (bin_w << FRAC_BITS) - $urandom_range(0, 1);
            default: v = $urandom_range(0, ((bin_n + 1) * bin_w) << FRAC_BITS);
        endcase
        return v[PIX_W-1:0];
    endfunction

    // Offers one pixel beat, waits for the handshake, then updates the expectation.
    task automatic send_pixel(input t_pixel_row px);
        t_bin_report rep;
        bit          hit;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 3 * PIX_W){1'b0}}, px.h, px.c, px.l};
        s_axis_tlast  <= px.last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (px.typed) begin
            // A lone pixel: its three bins hold one count and the full 100 percent.
            tally_pixel(px, 1'b0);
            for (int i = 0; i < NUM_BINS; i++) begin
                hit      = (i == px.bl || i == px.bc || i == px.bh);
                rep.idx  = BIN_IDX_W'(i);
                rep.cnt  = hit ? OUT_CNT_W'(1) : '0;
                rep.pct  = hit ? PCT_W'(PCT_SCALE) : '0;
                rep.last = (i == NUM_BINS - 1);
                bin_reports_q.push_back(rep);
            end
        end else begin
            tally_pixel(px, 1'b1);
        end
        // Occasional gap between beats.
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Lowers valid and waits until every reported bin has arrived.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bin_reports_q.size() != 0) @(posedge i_clk);
    endtask

    // Directed rows: lone pixels at the extremes and bin edges, then two short images.
    t_pixel_row directed_rows [18] = '{
        '{0, 0, 0, 1, 1, 9, 19, 37},
        '{16383, 16383, 16383, 1, 1, 0, 10, 20},
        '{-16384, -16384, -16384, 1, 1, NO_BIN, NO_BIN, NO_BIN},
        '{-1, -1, -1, 1, 1, NO_BIN, NO_BIN, NO_BIN},
        '{159, 160, 319, 1, 1, 9, 18, 37},
        '{160, 159, 320, 1, 1, 8, 19, 36},
        '{1439, 1440, 5439, 1, 1, 1, 10, 21},
        '{1440, 1439, 5440, 1, 1, 0, 11, 20},
        '{15, 1599, 5760, 1, 1, 9, 10, 20},
        '{800, 400, 2000, 0, 0, 0, 0, 0},
        '{-5, 1000, -7, 0, 0, 0, 0, 0},
        '{1200, 20, 3000, 0, 0, 0, 0, 0},
        '{100, 100, 100, 0, 0, 0, 0, 0},
        '{16383, -16384, 5440, 0, 0, 0, 0, 0},
        '{3, 3, 3, 1, 0, 0, 0, 0},
        '{500, 500, 500, 0, 0, 0, 0, 0},
        '{500, 500, 500, 0, 0, 0, 0, 0},
        '{1600, 0, 0, 1, 0, 0, 0, 0}
    };

    // Stimulus: reset, directed table, random images, then the final drain.
    initial begin
        t_pixel_row px;
        int         rand_items;
        int         img_len;
        bit         first_img;
        for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
        pixel_tally = '0;
        rand_items = 0;
        first_img = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) send_pixel(directed_rows[r]);
        drain_reports();

        while (rand_items < RAND_ITEMS) begin
            img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
            if (img_len > RAND_ITEMS - rand_items) img_len = RAND_ITEMS - rand_items;
            for (int k = 0; k < img_len; k++) begin
                calm_tail = (rand_items >= RAND_ITEMS - CALM_ITEMS);
                px.l     = chan_value(L_BIN_W, L_BIN_N);
                px.c     = chan_value(C_BIN_W, C_BIN_N);
                px.h     = chan_value(H_BIN_W, H_BIN_N);
                px.last  = (k == img_len - 1);
                px.typed = 1'b0;
                send_pixel(px);
                rand_items++;
            end
            // The report of the first random image meets a long output stall
            // while the next image is already being offered.
            if (first_img) begin
                long_hold_req = 1'b1;
                first_img     = 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                drain_reports();
            end
        end

        drain_reports();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Output side: random stalls, one long hold-off, steady ready at the end.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (calm_tail || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Compares every accepted result beat with the oldest expected bin.
    always @(posedge i_clk) begin : check_bins
        t_bin_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (bin_reports_q.size() == 0) begin
                $error("unexpected result beat: bin_index %0d", m_axis_tdata[5:0]);
                err_cnt++;
            end else begin
                want = bin_reports_q.pop_front();
                if (m_axis_tdata[5:0] !== want.idx) begin
                    $error("bin_index: expected %0d, got %0d", want.idx, m_axis_tdata[5:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[27:6] !== want.cnt) begin
                    $error("bin_count: expected %0d, got %0d", want.cnt, m_axis_tdata[27:6]);
                    err_cnt++;
                end
                if (m_axis_tdata[42:28] !== want.pct) begin
                    $error("bin_percent: expected %0d, got %0d", want.pct,
                           m_axis_tdata[42:28]);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_bin: expected %0d, got %0d", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
